### hdl/d2dt_pkg.sv
// ----------------------------------------------------------------------------
// d2dt_pkg
// Shared types, constants and helpers for the binary64 to decimal text block.
// ----------------------------------------------------------------------------
package d2dt_pkg;

  // Text layout
  localparam int unsigned INT_DIGITS      = 20;
  localparam int unsigned FRAC_DIGITS_DEF = 6;
  localparam int unsigned BCD_W           = 4 * INT_DIGITS;

  // binary64 layout
  localparam int unsigned VAL_W  = 64;
  localparam int unsigned EXP_W  = 11;
  localparam int unsigned MAN_W  = 52;
  localparam int unsigned SIG_W  = 53;
  localparam int unsigned FM_W   = 54;   // fraction significand, room for a round carry
  localparam int unsigned PROD_W = 57;   // significand times ten
  localparam int unsigned FE_W   = 12;   // signed exponent of the fraction lsb

  localparam logic [EXP_W-1:0] EXP_ALL_ONES = 11'h7FF;
  localparam logic [EXP_W-1:0] EXP_OVF      = 11'd1087;  // 2^64 and above

  // Binary to BCD: two shift-add-3 steps per cycle over the 64-bit integer
  localparam int unsigned DAB_PER_CYC = 2;
  localparam int unsigned CONV_CYCLES = VAL_W / DAB_PER_CYC;
  localparam int unsigned CNT_W       = 5;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WORD,
    ST_CONV,
    ST_SIGN,
    ST_SKIP,
    ST_INT,
    ST_POINT,
    ST_FMUL,
    ST_FDIG
  } state_e;

  typedef enum logic [2:0] {
    SEL_MINUS,
    SEL_INT,
    SEL_POINT,
    SEL_FRAC,
    SEL_WORD
  } char_sel_e;

  typedef enum logic [1:0] {
    WORD_NAN,
    WORD_INF,
    WORD_OVF
  } word_e;

  // Controller to datapath
  typedef struct packed {
    logic      load;
    logic      dabble;
    logic      shift_bcd;
    logic      fmul;
    logic      fdig;
    logic      emit;
    logic      last;
    char_sel_e sel;
    logic [1:0] word_idx;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic special;
    logic neg;
    logic top_zero;
  } stat_t;

  // Letters of the three special words
  function automatic logic [7:0] word_char(word_e w, logic [1:0] idx);
    logic [7:0] c;
    c = 8'h3F;
    unique case (w)
      WORD_NAN: c = (idx == 2'd1) ? 8'h61 : 8'h6E;
      WORD_INF: c = (idx == 2'd0) ? 8'h69 : ((idx == 2'd1) ? 8'h6E : 8'h66);
      WORD_OVF: c = (idx == 2'd0) ? 8'h6F : ((idx == 2'd1) ? 8'h76 : 8'h66);
      default:  c = 8'h3F;
    endcase
    return c;
  endfunction

endpackage

### hdl/double_to_decimal_text.sv
// ----------------------------------------------------------------------------
// double_to_decimal_text
// Formats a raw binary64 value as ASCII text, one character per beat.
// ----------------------------------------------------------------------------
//  channel | ports                                  | handshake
//  --------+----------------------------------------+--------------------------
//  input   | value_bits_i                           | start_i & !busy_o
//  result  | out_char_o, last_char_o                | out_valid_o strobe
//
//  nan/inf/ovf: a check state, then the three letters of the word.
//  Numbers: a check state, BCD conversion (2 bits per cycle), the sign when
//  negative, states that drop leading zeros and emit the integer digits, the
//  point, and for each fraction digit a multiply and a round-and-split state.
//  Reset is asynchronous; results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module double_to_decimal_text #(
  parameter int unsigned FRAC_DIGITS = d2dt_pkg::FRAC_DIGITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [63:0] value_bits_i,
  output logic        out_valid_o,
  output logic [7:0]  out_char_o,
  output logic        last_char_o
);
  import d2dt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  d2dt_ctrl #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  d2dt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_bits_i(value_bits_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

endmodule

### hdl/d2dt_dp.sv
// ----------------------------------------------------------------------------
// d2dt_dp
// Datapath: decode, binary to BCD, fraction times-ten unit, output register.
// ----------------------------------------------------------------------------
module d2dt_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [63:0]            value_bits_i,
  input  d2dt_pkg::cmd_t         cmd_i,
  output d2dt_pkg::stat_t        stat_o,
  output logic                   out_valid_o,
  output logic [7:0]             out_char_o,
  output logic                   last_char_o
);
  import d2dt_pkg::*;

  // One shift-add-3 step over {bcd, integer}
  function automatic logic [BCD_W+VAL_W-1:0] dab_step(logic [BCD_W+VAL_W-1:0] x);
    logic [BCD_W+VAL_W-1:0] y;
    y = x;
    for (int i = 0; i < INT_DIGITS; i++) begin
      if (y[VAL_W+4*i +: 4] >= 4'd5) begin
        y[VAL_W+4*i +: 4] = y[VAL_W+4*i +: 4] + 4'd3;
      end
    end
    return {y[BCD_W+VAL_W-2:0], 1'b0};
  endfunction

  logic [VAL_W-1:0]  ip_q;
  logic [BCD_W-1:0]  bcd_q;
  logic [FM_W-1:0]   fm_q;
  logic signed [FE_W-1:0] fe_q;
  logic [PROD_W-1:0] prod_q;
  word_e             word_q;
  logic              special_q, neg_q;
  logic              out_valid_q, last_q;
  logic [7:0]        char_q;

  // Decode of the incoming value
  logic [EXP_W-1:0] ex;
  logic [MAN_W-1:0] man;
  logic [SIG_W-1:0] sig;
  logic signed [FE_W-1:0] e_lsb;
  logic [FE_W-1:0]  rsh;
  logic [VAL_W-1:0] dec_ip, dec_mask;
  logic [FM_W-1:0]  dec_fm;
  logic signed [FE_W-1:0] dec_fe;
  word_e            dec_word;

  always_comb begin
    ex    = value_bits_i[62:52];
    man   = value_bits_i[51:0];
    sig   = {(ex != '0), man};
    e_lsb = (ex == '0) ? -12'sd1074 : ($signed({1'b0, ex}) - 12'sd1075);
    rsh   = FE_W'(-e_lsb);
    dec_mask = '0;
    if (!e_lsb[FE_W-1]) begin
      dec_ip = {11'b0, sig} << e_lsb[3:0];
      dec_fm = '0;
      dec_fe = '0;
    end else if (rsh >= FE_W'(VAL_W)) begin
      dec_ip = '0;
      dec_fm = {1'b0, sig};
      dec_fe = e_lsb;
    end else begin
      dec_ip   = {11'b0, sig} >> rsh[5:0];
      dec_mask = (64'h1 << rsh[5:0]) - 64'h1;
      dec_fm   = {1'b0, sig} & dec_mask[FM_W-1:0];
      dec_fe   = e_lsb;
    end
    if (ex == EXP_ALL_ONES) begin
      dec_word = (man != '0) ? WORD_NAN : WORD_INF;
    end else begin
      dec_word = WORD_OVF;
    end
  end

  // Round product to 53 bits (nearest even) and split off the digit
  logic [2:0]        k;
  logic [PROD_W-1:0] p_sh, p_rem, p_half, p_low;
  logic              rnd_up;
  logic [FM_W-1:0]   r;
  logic signed [FE_W-1:0] e_new;
  logic [FE_W-1:0]   fsh;
  logic [PROD_W-1:0] wide;
  logic [FM_W-1:0]   q, fmask;
  logic [3:0]        dig;
  logic [FM_W-1:0]   nx_fm;

  always_comb begin
    if (prod_q[56])      k = 3'd4;
    else if (prod_q[55]) k = 3'd3;
    else if (prod_q[54]) k = 3'd2;
    else if (prod_q[53]) k = 3'd1;
    else                 k = 3'd0;
    p_sh   = prod_q >> k;
    p_low  = (57'h1 << k) - 57'h1;
    p_rem  = prod_q & p_low;
    p_half = (k == 3'd0) ? '0 : (57'h1 << (k - 3'd1));
    rnd_up = (k != 3'd0) && ((p_rem > p_half) || ((p_rem == p_half) && p_sh[0]));
    r      = p_sh[FM_W-1:0] + FM_W'(rnd_up);
    e_new  = fe_q + $signed({9'b0, k});
    fsh    = FE_W'(-e_new);
    wide   = '0;
    q      = '0;
    fmask  = '0;
    if (!e_new[FE_W-1]) begin
      // Integer valued product: no fraction left
      wide  = {3'b0, r} << e_new[1:0];
      if (e_new > 12'sd3)            dig = 4'd0;
      else if (wide >= 57'd10)       dig = 4'd10;
      else                           dig = wide[3:0];
      nx_fm = '0;
    end else if (fsh >= FE_W'(PROD_W)) begin
      dig   = 4'd0;
      nx_fm = r;
    end else begin
      q     = r >> fsh[5:0];
      fmask = (54'h1 << fsh[5:0]) - 54'h1;
      dig   = (q >= 54'd10) ? 4'd10 : q[3:0];
      nx_fm = r & fmask;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ip_q      <= dec_ip;
      bcd_q     <= '0;
      fm_q      <= dec_fm;
      fe_q      <= dec_fe;
      word_q    <= dec_word;
      special_q <= (ex == EXP_ALL_ONES) || (ex >= EXP_OVF);
      neg_q     <= value_bits_i[63] && (value_bits_i[62:0] != '0);
    end else if (cmd_i.dabble) begin
      {bcd_q, ip_q} <= dab_step(dab_step({bcd_q, ip_q}));
    end else if (cmd_i.shift_bcd) begin
      bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
    end
    if (cmd_i.fmul) begin
      prod_q <= ({3'b0, fm_q} << 3) + ({3'b0, fm_q} << 1);
    end
    if (cmd_i.fdig) begin
      fm_q <= nx_fm;
      fe_q <= e_new;
    end
  end

  // Output character
  always_ff @(posedge clk_i) begin
    case (cmd_i.sel)
      SEL_MINUS: char_q <= CH_MINUS;
      SEL_INT:   char_q <= CH_ZERO + {4'd0, bcd_q[BCD_W-1 -: 4]};
      SEL_POINT: char_q <= CH_POINT;
      SEL_FRAC:  char_q <= CH_ZERO + {4'd0, dig};
      SEL_WORD:  char_q <= word_char(word_q, cmd_i.word_idx);
      default:   char_q <= CH_POINT;
    endcase
    last_q <= cmd_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.emit;
    end
  end

  assign stat_o.special  = special_q;
  assign stat_o.neg      = neg_q;
  assign stat_o.top_zero = (bcd_q[BCD_W-1 -: 4] == 4'd0);
  assign out_valid_o     = out_valid_q;
  assign out_char_o      = char_q;
  assign last_char_o     = last_q & out_valid_q;

endmodule

### hdl/d2dt_ctrl.sv
// ----------------------------------------------------------------------------
// d2dt_ctrl
// Sequencer: walks the datapath through conversion and character output.
// ----------------------------------------------------------------------------
module d2dt_ctrl #(
  parameter int unsigned FRAC_DIGITS = d2dt_pkg::FRAC_DIGITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  d2dt_pkg::stat_t stat_i,
  output d2dt_pkg::cmd_t  cmd_o,
  output logic            busy_o
);
  import d2dt_pkg::*;

  localparam int unsigned FW = $clog2(FRAC_DIGITS + 1);
  localparam logic [FW-1:0]    FLAST     = FW'(FRAC_DIGITS - 1);
  localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(CONV_CYCLES - 1);
  localparam logic [CNT_W-1:0] INT_N     = CNT_W'(INT_DIGITS);

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [FW-1:0]    fcnt_q, fcnt_d;

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    fcnt_d  = fcnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        cnt_d   = '0;
        state_d = stat_i.special ? ST_WORD : ST_CONV;
      end
      ST_WORD: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(2)) state_d = ST_IDLE;
      end
      ST_CONV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CONV_LAST) begin
          cnt_d   = INT_N;
          state_d = stat_i.neg ? ST_SIGN : ST_SKIP;
        end
      end
      ST_SIGN: state_d = ST_SKIP;
      ST_SKIP: begin
        if (stat_i.top_zero && (cnt_q > CNT_W'(1))) begin
          cnt_d = cnt_q - 1'b1;
        end else begin
          state_d = ST_INT;
        end
      end
      ST_INT: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) state_d = ST_POINT;
      end
      ST_POINT: begin
        fcnt_d  = '0;
        state_d = ST_FMUL;
      end
      ST_FMUL: state_d = ST_FDIG;
      ST_FDIG: begin
        fcnt_d  = fcnt_q + 1'b1;
        state_d = (fcnt_q == FLAST) ? ST_IDLE : ST_FMUL;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    cmd_o.sel = SEL_POINT;
    unique case (state_q)
      ST_IDLE:  cmd_o.load = start_i;
      ST_CHECK: ;
      ST_WORD: begin
        cmd_o.emit     = 1'b1;
        cmd_o.sel      = SEL_WORD;
        cmd_o.word_idx = cnt_q[1:0];
        cmd_o.last     = (cnt_q == CNT_W'(2));
      end
      ST_CONV:  cmd_o.dabble = 1'b1;
      ST_SIGN: begin
        cmd_o.emit = 1'b1;
        cmd_o.sel  = SEL_MINUS;
      end
      ST_SKIP:  cmd_o.shift_bcd = stat_i.top_zero && (cnt_q > CNT_W'(1));
      ST_INT: begin
        cmd_o.emit      = 1'b1;
        cmd_o.sel       = SEL_INT;
        cmd_o.shift_bcd = 1'b1;
      end
      ST_POINT: cmd_o.emit = 1'b1;
      ST_FMUL:  cmd_o.fmul = 1'b1;
      ST_FDIG: begin
        cmd_o.fdig = 1'b1;
        cmd_o.emit = 1'b1;
        cmd_o.sel  = SEL_FRAC;
        cmd_o.last = (fcnt_q == FLAST);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      fcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      fcnt_q  <= fcnt_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

### hdl/d2dt_checker.sv
// ----------------------------------------------------------------------------
// d2dt_checker
// Port-level checks on the formatter, bound to the top level.
// ----------------------------------------------------------------------------
module d2dt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       out_valid_o,
  input logic       last_char_o,
  input logic [7:0] out_char_o
);

  // Accepted item makes the block busy
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("not busy after accepted beat");

  // Idle block emits nothing in the next cycle
  a_quiet_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |=> !out_valid_o)
    else $error("result beat without work");

  // Last marker only on a valid beat
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_char_o |-> out_valid_o)
    else $error("last without strobe");

  // A non-final beat means more is coming, so the block is still busy
  a_busy_mid_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_char_o) |-> busy_o)
    else $error("idle in the middle of a text");

  // Character bits are known on every result beat
  a_char_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$isunknown({out_char_o, last_char_o}))
    else $error("unknown character on a result beat");

endmodule

bind double_to_decimal_text d2dt_checker u_d2dt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .out_valid_o(out_valid_o),
  .last_char_o(last_char_o),
  .out_char_o (out_char_o)
);
